// File: sv/sr_arq_receive_reorder_defines.svh
// Assertion macros for the reorder receiver checkers
`ifndef SR_ARQ_RECEIVE_REORDER_DEFINES_SVH
`define SR_ARQ_RECEIVE_REORDER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sra_pkg.sv
// Types, constants and helpers shared by the reorder receiver
package sra_pkg;

  localparam int unsigned PAYLOAD_BYTES = 20;
  localparam logic [7:0]  ACK_FILL      = 8'h30;
  localparam logic [31:0] ACK_CHECK     = 32'(PAYLOAD_BYTES * 48);
  localparam logic [63:0] ACK_WORD64    = {8{ACK_FILL}};
  localparam logic [31:0] ACK_WORD32    = {4{ACK_FILL}};

  typedef struct packed {
    logic [31:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } payload_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_ACK,
    ST_DELIV
  } st_e;

  // signed sum of the low n bytes of a word
  function automatic logic signed [12:0] byte_sum(input logic [63:0] w, input int unsigned n);
    logic signed [12:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        acc = acc + 13'(signed'(w[8*i +: 8]));
      end
    end
    return acc;
  endfunction

endpackage

// File: sv/sra_if.sv
// Valid/ready channels for received packets and for results
interface sra_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pkt_seq;
  logic signed [31:0] pkt_ack;
  logic signed [31:0] pkt_sum;
  logic [63:0]        payload_word0;
  logic [63:0]        payload_word1;
  logic [31:0]        payload_word2;

  modport source (
    output valid, pkt_seq, pkt_ack, pkt_sum, payload_word0, payload_word1, payload_word2,
    input  ready
  );
  modport sink (
    input  valid, pkt_seq, pkt_ack, pkt_sum, payload_word0, payload_word1, payload_word2,
    output ready
  );
endinterface

interface sra_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               ack_bit;
  logic signed [31:0] ack_number;
  logic signed [31:0] ack_check;
  logic [63:0]        out_word0;
  logic [63:0]        out_word1;
  logic [31:0]        out_word2;
  logic [2:0]         delivered_seq;
  logic               last;

  modport source (
    output valid, kind, ack_bit, ack_number, ack_check, out_word0, out_word1, out_word2,
           delivered_seq, last,
    input  ready
  );
  modport sink (
    input  valid, kind, ack_bit, ack_number, ack_check, out_word0, out_word1, out_word2,
           delivered_seq, last,
    output ready
  );
endinterface

// File: sv/sra_cell.sv
// One receive-window slot: filled flag and stored payload, shifts towards slot zero
module sra_cell import sra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       nb_filled_i,
  input  payload_t   nb_payload_i,
  input  payload_t   wr_payload_i,
  output logic       filled_o,
  output payload_t   payload_o
);

  logic     filled_q, filled_d;
  payload_t payload_q, payload_d;

  always_comb begin
    filled_d  = filled_q;
    payload_d = payload_q;
    if (ctrl_i.shift) begin
      filled_d  = nb_filled_i;
      payload_d = nb_payload_i;
    end else if (ctrl_i.load) begin
      filled_d  = 1'b1;
      payload_d = wr_payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
    end else begin
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
  end

  assign filled_o  = filled_q;
  assign payload_o = payload_q;

endmodule

// File: sv/sr_arq_receive_reorder.sv
// Selective-repeat receiver with in-order reorder window (top level)
// A packet is taken when the block is idle. It is captured, its payload bytes
// are summed, it is checked and stored, and then its results leave one per
// cycle through the single output register while the output is not stalled:
// one ACK, then each in-order delivery (0..RECV_WINDOW of them). The window is a
// row of RECV_WINDOW slot cells that shifts by one on each delivery.
module sr_arq_receive_reorder import sra_pkg::*; #(
  parameter int unsigned SEQ_SPACE   = 7,
  parameter int unsigned RECV_WINDOW = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sra_in_if.sink    pkt_i,
  sra_out_if.source res_o
);

  localparam int unsigned BASE_W = $clog2(SEQ_SPACE);

  st_e state_q, state_d;

  logic signed [31:0] seq_q, ack_q, sum_q;
  payload_t           pay_q;
  logic signed [12:0] psum0_q, psum1_q, psum2_q;

  logic [BASE_W-1:0] base_q, base_d;
  logic              toggle_q;

  logic              out_valid_q;
  logic              out_kind_q, out_bit_q, out_last_q;
  logic [31:0]       out_num_q, out_chk_q;
  payload_t          out_pay_q;
  logic [2:0]        out_dseq_q;

  logic              out_free;
  logic              in_take, do_sum, store_en, ack_load, dlv_load;

  logic signed [12:0] psum_all;
  logic [31:0]        calc;
  logic               seq_ok;
  logic [BASE_W:0]    diff;
  logic [BASE_W-1:0]  rel;

  logic     filled_w [RECV_WINDOW+1];
  payload_t payload_w[RECV_WINDOW+1];

  assign out_free = !out_valid_q || res_o.ready;

  // checksum and window position
  assign psum_all = psum0_q + psum1_q + psum2_q;
  assign calc     = seq_q + ack_q + {{19{psum_all[12]}}, psum_all};
  assign seq_ok   = (calc == sum_q) && ($unsigned(seq_q) < SEQ_SPACE);
  assign diff     = {1'b0, seq_q[BASE_W-1:0]} - {1'b0, base_q};
  assign rel      = diff[BASE_W] ? BASE_W'(diff + (BASE_W+1)'(SEQ_SPACE)) : diff[BASE_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (pkt_i.valid) state_d = ST_SUM;
      ST_SUM:   state_d = ST_CHECK;
      ST_CHECK: state_d = ST_ACK;
      ST_ACK: begin
        if (out_free) state_d = filled_w[0] ? ST_DELIV : ST_IDLE;
      end
      ST_DELIV: begin
        if (out_free && !filled_w[1]) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_take  = 1'b0;
    do_sum   = 1'b0;
    store_en = 1'b0;
    ack_load = 1'b0;
    dlv_load = 1'b0;
    case (state_q)
      ST_IDLE:  in_take  = pkt_i.valid;
      ST_SUM:   do_sum   = 1'b1;
      ST_CHECK: store_en = seq_ok;
      ST_ACK:   ack_load = out_free;
      ST_DELIV: dlv_load = out_free;
      default: ;
    endcase
  end

  assign pkt_i.ready = (state_q == ST_IDLE);

  assign base_d = dlv_load ? ((base_q == BASE_W'(SEQ_SPACE - 1)) ? '0 : base_q + 1'b1) : base_q;

  // slot cells
  assign filled_w[RECV_WINDOW]  = 1'b0;
  assign payload_w[RECV_WINDOW] = '0;

  for (genvar k = 0; k < RECV_WINDOW; k++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.shift = dlv_load;
    assign ctrl.load  = store_en && (32'(rel) == 32'(k)) && !filled_w[k];

    sra_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .nb_filled_i  (filled_w[k+1]),
      .nb_payload_i (payload_w[k+1]),
      .wr_payload_i (pay_q),
      .filled_o     (filled_w[k]),
      .payload_o    (payload_w[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      toggle_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      if (ack_load) toggle_q <= !toggle_q;
      if (ack_load || dlv_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      seq_q    <= pkt_i.pkt_seq;
      ack_q    <= pkt_i.pkt_ack;
      sum_q    <= pkt_i.pkt_sum;
      pay_q.w0 <= pkt_i.payload_word0;
      pay_q.w1 <= pkt_i.payload_word1;
      pay_q.w2 <= pkt_i.payload_word2;
    end
    if (do_sum) begin
      psum0_q <= byte_sum(pay_q.w0, 8);
      psum1_q <= byte_sum(pay_q.w1, 8);
      psum2_q <= byte_sum({32'b0, pay_q.w2}, 4);
    end
    if (ack_load) begin
      out_kind_q <= 1'b0;
      out_bit_q  <= toggle_q;
      out_num_q  <= seq_q;
      out_chk_q  <= {31'b0, toggle_q} + seq_q + ACK_CHECK;
      out_pay_q  <= '{w2: ACK_WORD32, w1: ACK_WORD64, w0: ACK_WORD64};
      out_dseq_q <= '0;
      out_last_q <= !filled_w[0];
    end else if (dlv_load) begin
      out_kind_q <= 1'b1;
      out_bit_q  <= 1'b0;
      out_num_q  <= '0;
      out_chk_q  <= '0;
      out_pay_q  <= payload_w[0];
      out_dseq_q <= 3'(base_q);
      out_last_q <= !filled_w[1];
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = out_kind_q;
  assign res_o.ack_bit       = out_bit_q;
  assign res_o.ack_number    = out_num_q;
  assign res_o.ack_check     = out_chk_q;
  assign res_o.out_word0     = out_pay_q.w0;
  assign res_o.out_word1     = out_pay_q.w1;
  assign res_o.out_word2     = out_pay_q.w2;
  assign res_o.delivered_seq = out_dseq_q;
  assign res_o.last          = out_last_q;

endmodule

// File: sv/sra_checker.sv
// Port-level checks on the reorder receiver results, bound to the top level
`include "sr_arq_receive_reorder_defines.svh"

module sra_checker import sra_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic        out_ack_bit_i,
  input logic [31:0] out_ack_number_i,
  input logic [31:0] out_ack_check_i,
  input logic [63:0] out_word0_i,
  input logic [63:0] out_word1_i,
  input logic [31:0] out_word2_i,
  input logic [2:0]  out_dseq_i,
  input logic        out_last_i
);

  `SRA_ASSERT_NOW(a_ack_check, out_valid_i && !out_kind_i, out_ack_check_i == {31'b0, out_ack_bit_i} + out_ack_number_i + ACK_CHECK, "ACK checksum wrong")
  `SRA_ASSERT_NOW(a_ack_fill, out_valid_i && !out_kind_i, out_word0_i == ACK_WORD64 && out_word1_i == ACK_WORD64 && out_word2_i == ACK_WORD32 && out_dseq_i == 3'd0, "ACK payload not fill bytes")
  `SRA_ASSERT_NOW(a_dlv_zero, out_valid_i && out_kind_i, !out_ack_bit_i && out_ack_number_i == 32'd0 && out_ack_check_i == 32'd0, "delivery carries ACK fields")
  `SRA_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_word0_i) && $stable(out_last_i) && $stable(out_dseq_i), "stalled result changed")

endmodule

bind sr_arq_receive_reorder sra_checker u_sra_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .out_kind_i       (res_o.kind),
  .out_ack_bit_i    (res_o.ack_bit),
  .out_ack_number_i (res_o.ack_number),
  .out_ack_check_i  (res_o.ack_check),
  .out_word0_i      (res_o.out_word0),
  .out_word1_i      (res_o.out_word1),
  .out_word2_i      (res_o.out_word2),
  .out_dseq_i       (res_o.delivered_seq),
  .out_last_i       (res_o.last)
);
